// File: src/gda_pkg.sv
package gda_pkg;

    // Day numbers reach about 6.0M for year 16383, so 23 bits hold them.
    localparam int DN_W  = 23;
    localparam int SUM_W = DN_W + 2;   // signed sums of a day number and an amount
    localparam int YR_W  = 14;
    localparam int MO_W  = 4;
    localparam int DY_W  = 5;
    localparam int OUT_W = 22;
    localparam int STEPS = 15;         // digit steps of one year/day decomposition
    localparam int IDX_W = 4;
    localparam int QUO_W = STEPS;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_ADD_DAYS,
        CMD_ADD_YEARS,
        CMD_DIFF
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_YSTEP,
        ST_MADD,
        ST_CHECK,
        ST_DSTEP,
        ST_MSTEP,
        ST_DIFF,
        ST_DONE
    } t_state;

    // Per step: a weight in years and the matching weight in days.
    typedef struct packed {
        logic [DN_W-1:0] yr;
        logic [DN_W-1:0] dy;
    } t_step_k;

    typedef struct packed {
        logic in_valid;
        logic src_in;
        logic move_req;
        logic other_req;
        logic range_ok;
        logic month_done;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic             idle;
        logic             ld;
        logic             setup;
        logic             ystep;
        logic             madd;
        logic             start_other;
        logic             check;
        logic             dstep;
        logic             mstep;
        logic             diff;
        logic             done_ld;
        logic [IDX_W-1:0] idx;
    } t_ctrl;

    // 400-year, 100-year, 4-year and 1-year weights, binary digits high first.
    function automatic t_step_k step_k(input logic [IDX_W-1:0] idx);
        t_step_k k;
        unique case (idx)
            4'd0:    k = '{yr: DN_W'(12800), dy: DN_W'(4675104)};
            4'd1:    k = '{yr: DN_W'(6400),  dy: DN_W'(2337552)};
            4'd2:    k = '{yr: DN_W'(3200),  dy: DN_W'(1168776)};
            4'd3:    k = '{yr: DN_W'(1600),  dy: DN_W'(584388)};
            4'd4:    k = '{yr: DN_W'(800),   dy: DN_W'(292194)};
            4'd5:    k = '{yr: DN_W'(400),   dy: DN_W'(146097)};
            4'd6:    k = '{yr: DN_W'(200),   dy: DN_W'(73048)};
            4'd7:    k = '{yr: DN_W'(100),   dy: DN_W'(36524)};
            4'd8:    k = '{yr: DN_W'(64),    dy: DN_W'(23376)};
            4'd9:    k = '{yr: DN_W'(32),    dy: DN_W'(11688)};
            4'd10:   k = '{yr: DN_W'(16),    dy: DN_W'(5844)};
            4'd11:   k = '{yr: DN_W'(8),     dy: DN_W'(2922)};
            4'd12:   k = '{yr: DN_W'(4),     dy: DN_W'(1461)};
            4'd13:   k = '{yr: DN_W'(2),     dy: DN_W'(730)};
            4'd14:   k = '{yr: DN_W'(1),     dy: DN_W'(365)};
            default: k = '{yr: '0, dy: '0};
        endcase
        return k;
    endfunction

    function automatic logic [8:0] month_start(input logic [MO_W-1:0] m);
        logic [8:0] s;
        unique case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [DY_W-1:0] month_len(input logic [MO_W-1:0] m, input logic lp);
        logic [DY_W-1:0] n;
        unique case (m)
            4'd2:                               n = lp ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:            n = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            default:                            n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic month_ok(input logic [MO_W-1:0] m);
        return (m >= 4'd1) && (m <= 4'd12);
    endfunction

    // Digits {q400[5:0], c[1:0], f[4:0], y1[1:0]}; leap when the year is the
    // last of its 4-year group, unless it ends a century that is not a 400th.
    function automatic logic leap_of(input logic [QUO_W-1:0] q);
        return (q[1:0] == 2'd3) && ((q[6:2] != 5'd24) || (q[8:7] == 2'd3));
    endfunction

endpackage

// File: src/gda_step_unit.sv
module gda_step_unit (
    input  logic [gda_pkg::DN_W-1:0] i_rem,
    input  logic [gda_pkg::DN_W-1:0] i_acc,
    input  logic [gda_pkg::DN_W-1:0] i_rem_k,
    input  logic [gda_pkg::DN_W-1:0] i_acc_k,
    output logic [gda_pkg::DN_W-1:0] o_rem,
    output logic [gda_pkg::DN_W-1:0] o_acc,
    output logic                     o_take
);
    import gda_pkg::*;

    logic [DN_W:0]   sub;
    logic [DN_W-1:0] sum;

    // conditional subtract on the remainder, matching add on the accumulator
    assign sub    = {1'b0, i_rem} - {1'b0, i_rem_k};
    assign sum    = i_acc + i_acc_k;
    assign o_take = ~sub[DN_W];
    assign o_rem  = o_take ? sub[DN_W-1:0] : i_rem;
    assign o_acc  = o_take ? sum : i_acc;

endmodule

// File: src/gda_ctrl.sv
module gda_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gda_pkg::t_stat i_stat,
    output gda_pkg::t_ctrl o_ctrl
);
    import gda_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(STEPS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        unique case (r_state)
            ST_IDLE:  if (i_stat.in_valid) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_YSTEP;
            ST_YSTEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_MADD;
                end
            end
            ST_MADD: begin
                priority if (i_stat.src_in)    n_state = ST_DIFF;
                else if (i_stat.move_req)      n_state = ST_CHECK;
                else if (i_stat.other_req)     n_state = ST_YSTEP;
                else                           n_state = ST_DONE;
            end
            ST_CHECK: n_state = i_stat.range_ok ? ST_DSTEP : ST_DONE;
            ST_DSTEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_MSTEP;
                end
            end
            ST_MSTEP: if (i_stat.month_done) n_state = ST_DONE;
            ST_DIFF:  n_state = ST_DONE;
            ST_DONE:  if (i_stat.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control decode
    always_comb begin
        o_ctrl             = '0;
        o_ctrl.idx         = r_cnt;
        o_ctrl.idle        = (r_state == ST_IDLE);
        o_ctrl.ld          = (r_state == ST_IDLE) && i_stat.in_valid;
        o_ctrl.setup       = (r_state == ST_SETUP);
        o_ctrl.ystep       = (r_state == ST_YSTEP);
        o_ctrl.madd        = (r_state == ST_MADD);
        o_ctrl.start_other = (r_state == ST_MADD) && !i_stat.src_in &&
                             !i_stat.move_req && i_stat.other_req;
        o_ctrl.check       = (r_state == ST_CHECK);
        o_ctrl.dstep       = (r_state == ST_DSTEP);
        o_ctrl.mstep       = (r_state == ST_MSTEP);
        o_ctrl.diff        = (r_state == ST_DIFF);
        o_ctrl.done_ld     = (r_state == ST_DONE) && i_stat.out_free;
    end

endmodule

// File: src/gregorian_date_arithmetic.sv
// Load and add years decompose the stored year once; add days follows with the day
//   decomposition and month walk; difference decomposes both years, then subtracts.
// Flow: one command at a time; the next input beat is taken once the current one is handed
//   to the output register (one beat may wait there).
// Reset (synchronous, active low): stored date 0001-01-01, sequencer idle, no result pending.
module gregorian_date_arithmetic #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_command,
    input  logic [gda_pkg::MO_W-1:0]        i_month_in,
    input  logic [gda_pkg::DY_W-1:0]        i_day_in,
    input  logic [gda_pkg::YR_W-1:0]        i_year_in,
    input  logic signed [22:0]              i_amount,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [gda_pkg::MO_W-1:0]        o_month_out,
    output logic [gda_pkg::DY_W-1:0]        o_day_out,
    output logic [gda_pkg::YR_W-1:0]        o_year_out,
    output logic [gda_pkg::OUT_W-1:0]       o_day_number,
    output logic [gda_pkg::OUT_W-1:0]       o_difference,
    output logic                            o_date_valid,
    output logic                            o_out_of_range
);
    import gda_pkg::*;

    // Days in years 1..MAX_YEAR: the last day number that a move may reach.
    localparam int DMAX = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
    localparam logic signed [SUM_W-1:0] DMAX_S = SUM_W'(DMAX);
    localparam logic signed [SUM_W-1:0] MAXY_S = SUM_W'(MAX_YEAR);
    localparam logic [YR_W-1:0]         MAXY_U = YR_W'(MAX_YEAR);

    t_stat stat;
    t_ctrl ctrl;

    // latched command
    t_cmd               r_cmd, n_cmd;
    logic [MO_W-1:0]    r_mi, n_mi;
    logic [DY_W-1:0]    r_di, n_di;
    logic [YR_W-1:0]    r_yi, n_yi;
    logic signed [22:0] r_amt, n_amt;

    // stored date
    logic [MO_W-1:0] r_cur_m, n_cur_m;
    logic [DY_W-1:0] r_cur_d, n_cur_d;
    logic [YR_W-1:0] r_cur_y, n_cur_y;

    // working registers of the shared unit
    logic [DN_W-1:0]  r_rem, n_rem;
    logic [DN_W-1:0]  r_acc, n_acc;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [MO_W-1:0]  r_mon, n_mon;
    logic             r_src_in, n_src_in;
    logic [DN_W-1:0]  r_dn, n_dn;
    logic [OUT_W-1:0] r_diff, n_diff;
    logic             r_oor, n_oor;
    logic             r_fix, n_fix;
    logic             r_leap, n_leap;

    // output register
    logic             r_o_valid, n_o_valid;
    logic [MO_W-1:0]  r_o_m, n_o_m;
    logic [DY_W-1:0]  r_o_d, n_o_d;
    logic [YR_W-1:0]  r_o_y, n_o_y;
    logic [OUT_W-1:0] r_o_dn, n_o_dn;
    logic [OUT_W-1:0] r_o_diff, n_o_diff;
    logic             r_o_dv, n_o_dv;
    logic             r_o_oor, n_o_oor;

    // shared unit operands
    logic [DN_W-1:0] u_rem_k, u_acc_k, u_rem, u_acc;
    logic            u_take;
    t_step_k         k;
    logic            leap_q;
    logic [MO_W-1:0] m_src;
    logic [DY_W-1:0] d_src;
    logic [9:0]      addend;

    logic signed [SUM_W-1:0] amt_x, nn, nn_m1, ny;
    logic                    nn_ok, ny_ok, yi_ok;
    logic [DN_W:0]           dsub;
    logic [DN_W-1:0]         dabs;

    assign k      = step_k(ctrl.idx);
    assign leap_q = leap_of(r_quo);
    assign m_src  = r_src_in ? r_mi : r_cur_m;
    assign d_src  = r_src_in ? r_di : r_cur_d;
    // month offset, Feb 29 of a leap year, and the day itself
    assign addend = 10'(month_start(m_src)) + 10'((m_src > 4'd2) && leap_q) + 10'(d_src);

    // signed move checks
    assign amt_x = SUM_W'(r_amt);
    assign nn    = $signed({2'b00, r_dn}) + amt_x;
    assign nn_m1 = nn - SUM_W'(1);
    assign nn_ok = (nn >= SUM_W'(1)) && (nn <= DMAX_S);
    assign ny    = $signed({{(SUM_W-YR_W){1'b0}}, r_cur_y}) + amt_x;
    assign ny_ok = (ny >= SUM_W'(1)) && (ny <= MAXY_S);
    assign yi_ok = (r_yi != '0) && (r_yi <= MAXY_U);

    assign dsub = {1'b0, r_acc} - {1'b0, r_dn};
    assign dabs = dsub[DN_W] ? (r_dn - r_acc) : dsub[DN_W-1:0];

    // Operand select: year digits (year -> days), day digits (days -> year),
    // month walk, or a plain add onto the accumulator.
    always_comb begin
        priority if (ctrl.ystep) begin
            u_rem_k = k.yr;
            u_acc_k = k.dy;
        end else if (ctrl.dstep) begin
            u_rem_k = k.dy;
            u_acc_k = k.yr;
        end else if (ctrl.mstep) begin
            u_rem_k = DN_W'(month_len(r_mon, leap_q));
            u_acc_k = '0;
        end else begin
            u_rem_k = '0;
            u_acc_k = DN_W'(addend);
        end
    end

    gda_step_unit u_step (
        .i_rem   (r_rem),
        .i_acc   (r_acc),
        .i_rem_k (u_rem_k),
        .i_acc_k (u_acc_k),
        .o_rem   (u_rem),
        .o_acc   (u_acc),
        .o_take  (u_take)
    );

    always_comb begin
        stat.in_valid   = i_valid;
        stat.src_in     = r_src_in;
        stat.move_req   = (r_cmd == CMD_ADD_DAYS) && month_ok(r_cur_m) && (r_amt != '0);
        stat.other_req  = (r_cmd == CMD_DIFF) && month_ok(r_cur_m) &&
                          month_ok(r_mi) && (r_yi != '0);
        stat.range_ok   = nn_ok;
        stat.month_done = (r_mon == 4'd12) || !u_take;
        stat.out_free   = !r_o_valid || i_ready;
    end

    gda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    always_comb begin
        n_cmd    = r_cmd;
        n_mi     = r_mi;
        n_di     = r_di;
        n_yi     = r_yi;
        n_amt    = r_amt;
        n_cur_m  = r_cur_m;
        n_cur_d  = r_cur_d;
        n_cur_y  = r_cur_y;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_quo    = r_quo;
        n_mon    = r_mon;
        n_src_in = r_src_in;
        n_dn     = r_dn;
        n_diff   = r_diff;
        n_oor    = r_oor;
        n_fix    = r_fix;
        n_leap   = r_leap;

        if (ctrl.ld) begin
            n_cmd    = t_cmd'(i_command);
            n_mi     = i_month_in;
            n_di     = i_day_in;
            n_yi     = i_year_in;
            n_amt    = i_amount;
            n_oor    = 1'b0;
            n_fix    = 1'b0;
            n_diff   = '0;
            n_src_in = 1'b0;
        end

        if (ctrl.setup) begin
            unique case (r_cmd)
                CMD_LOAD: begin
                    if (yi_ok) begin
                        n_cur_m = r_mi;
                        n_cur_d = r_di;
                        n_cur_y = r_yi;
                    end else begin
                        n_oor = 1'b1;
                    end
                end
                CMD_ADD_YEARS: begin
                    if (ny_ok) begin
                        n_cur_y = ny[YR_W-1:0];
                        n_fix   = 1'b1;
                    end else begin
                        n_oor = 1'b1;
                    end
                end
                CMD_ADD_DAYS, CMD_DIFF: ;
                default: ;
            endcase
            // decompose (year - 1) of the stored date
            n_rem = DN_W'(n_cur_y - 1'b1);
            n_acc = '0;
            n_quo = '0;
        end

        if (ctrl.ystep || ctrl.dstep) begin
            n_rem = u_rem;
            n_acc = u_acc;
            n_quo = {r_quo[QUO_W-2:0], u_take};
        end

        if (ctrl.madd) begin
            n_acc = u_acc;
            if (!r_src_in) begin
                n_leap = leap_q;
                n_dn   = month_ok(r_cur_m) ? u_acc : '0;
                // Feb 29 lands in a common year: same day number as Mar 1
                if (r_fix && (r_cur_m == 4'd2) && (r_cur_d == 5'd29) && !leap_q) begin
                    n_cur_m = 4'd3;
                    n_cur_d = 5'd1;
                end
            end
            if (ctrl.start_other) begin
                n_rem    = DN_W'(r_yi - 1'b1);
                n_acc    = '0;
                n_quo    = '0;
                n_src_in = 1'b1;
            end
        end

        if (ctrl.check) begin
            if (nn_ok) begin
                n_dn  = nn[DN_W-1:0];
                n_rem = nn_m1[DN_W-1:0];
                n_acc = DN_W'(1);
                n_quo = '0;
                n_mon = 4'd1;
            end else begin
                n_oor = 1'b1;
            end
        end

        if (ctrl.mstep) begin
            if (!stat.month_done) begin
                n_rem = u_rem;
                n_mon = r_mon + 1'b1;
            end else begin
                n_cur_y = r_acc[YR_W-1:0];
                n_cur_m = r_mon;
                n_cur_d = r_rem[DY_W-1:0] + 1'b1;
                n_leap  = leap_q;
            end
        end

        if (ctrl.diff) begin
            n_diff = dabs[DN_W-1] ? '1 : dabs[OUT_W-1:0];
        end
    end

    // output register: loads when free or being drained
    always_comb begin
        n_o_valid = r_o_valid;
        n_o_m     = r_o_m;
        n_o_d     = r_o_d;
        n_o_y     = r_o_y;
        n_o_dn    = r_o_dn;
        n_o_diff  = r_o_diff;
        n_o_dv    = r_o_dv;
        n_o_oor   = r_o_oor;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        if (ctrl.done_ld) begin
            n_o_valid = 1'b1;
            n_o_m     = r_cur_m;
            n_o_d     = r_cur_d;
            n_o_y     = r_cur_y;
            n_o_dn    = r_dn[DN_W-1] ? '1 : r_dn[OUT_W-1:0];
            n_o_diff  = r_diff;
            n_o_dv    = month_ok(r_cur_m) && (r_cur_d != '0) &&
                        (r_cur_d <= month_len(r_cur_m, r_leap));
            n_o_oor   = r_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_m   <= 4'd1;
            r_cur_d   <= 5'd1;
            r_cur_y   <= 14'd1;
            r_o_valid <= 1'b0;
        end else begin
            r_cur_m   <= n_cur_m;
            r_cur_d   <= n_cur_d;
            r_cur_y   <= n_cur_y;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_mi     <= n_mi;
        r_di     <= n_di;
        r_yi     <= n_yi;
        r_amt    <= n_amt;
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_quo    <= n_quo;
        r_mon    <= n_mon;
        r_src_in <= n_src_in;
        r_dn     <= n_dn;
        r_diff   <= n_diff;
        r_oor    <= n_oor;
        r_fix    <= n_fix;
        r_leap   <= n_leap;
        r_o_m    <= n_o_m;
        r_o_d    <= n_o_d;
        r_o_y    <= n_o_y;
        r_o_dn   <= n_o_dn;
        r_o_diff <= n_o_diff;
        r_o_dv   <= n_o_dv;
        r_o_oor  <= n_o_oor;
    end

    assign o_ready        = ctrl.idle;
    assign o_valid        = r_o_valid;
    assign o_month_out    = r_o_m;
    assign o_day_out      = r_o_d;
    assign o_year_out     = r_o_y;
    assign o_day_number   = r_o_dn;
    assign o_difference   = r_o_diff;
    assign o_date_valid   = r_o_dv;
    assign o_out_of_range = r_o_oor;

endmodule

// File: src/gda_checker.sv
module gda_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [gda_pkg::MO_W-1:0]  o_month_out,
    input logic [gda_pkg::DY_W-1:0]  o_day_out,
    input logic [gda_pkg::YR_W-1:0]  o_year_out,
    input logic [gda_pkg::OUT_W-1:0] o_day_number,
    input logic [gda_pkg::OUT_W-1:0] o_difference,
    input logic                      o_date_valid,
    input logic                      o_out_of_range
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_month_out) && $stable(o_day_out) &&
        $stable(o_year_out) && $stable(o_day_number) && $stable(o_difference))
        else $error("result beat changed while stalled");

    // one command at a time: busy right after an input beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while a command is in flight");

    a_valid_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_date_valid |-> (o_month_out >= 4'd1) && (o_month_out <= 4'd12) &&
        (o_day_out != 5'd0))
        else $error("date flagged valid with bad month or day");

    a_oor_nodiff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> (o_difference == '0))
        else $error("refused move carries a difference");

    a_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_out != '0))
        else $error("stored year is zero");

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_month_out    (o_month_out),
    .o_day_out      (o_day_out),
    .o_year_out     (o_year_out),
    .o_day_number   (o_day_number),
    .o_difference   (o_difference),
    .o_date_valid   (o_date_valid),
    .o_out_of_range (o_out_of_range)
);
